>>> design/bpc_pkg.sv
// Package for the button press classifier.
// Holds configuration register indexes, reset values and the shared structs.
// No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned INTERVAL_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_LONG_THRESH  = 2'd1,
    REG_SAMPLE_INTV  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  localparam logic [IDLE_W-1:0]     IDLE_TIMEOUT_RST = 16'd3000;
  localparam logic [THRESH_W-1:0]   LONG_THRESH_RST  = 16'd200;
  localparam logic [INTERVAL_W-1:0] SAMPLE_INTV_RST  = 10'd20;

  typedef struct packed {
    logic [IDLE_W-1:0]     idle_timeout;
    logic [THRESH_W-1:0]   long_press_threshold;
    logic [INTERVAL_W-1:0] sample_interval;
  } cfg_t;

  typedef struct packed {
    logic is_pressed;
    logic press_event;
    logic release_event;
    logic short_press;
    logic long_press;
    logic idle_flag;
  } result_t;

endpackage

`default_nettype wire

>>> design/bpc_cfg_regs.sv
// Configuration register file of the button press classifier.
// Depends on bpc_pkg for register indexes and reset values.
`default_nettype none

module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_data_i[IDLE_W-1:0];
        REG_LONG_THRESH:  cfg_d.long_press_threshold = cfg_data_i[THRESH_W-1:0];
        REG_SAMPLE_INTV:  cfg_d.sample_interval = cfg_data_i[INTERVAL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout         <= IDLE_TIMEOUT_RST;
      cfg_q.long_press_threshold <= LONG_THRESH_RST;
      cfg_q.sample_interval      <= SAMPLE_INTV_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/bpc_core.sv
// Per-tick classifier: sample countdown, saturating elapsed timer, press state.
// Depends on bpc_pkg for the configuration and result structs.
`default_nettype none

module bpc_core
  import bpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,
  input  wire logic pin_level_i,
  input  wire cfg_t cfg_i,
  output logic      res_valid_o,
  output result_t   res_o
);

  localparam int unsigned CmpW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic                  pressed_q, pressed_d;
  logic [TIME_BITS-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic [INTERVAL_W-1:0] countdown_q, countdown_d;
  logic [CmpW-1:0]       elapsed_ext, thresh_ext, idle_ext;
  logic                  sample;

  assign elapsed_inc = (elapsed_q != {TIME_BITS{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
  assign elapsed_ext = CmpW'(elapsed_inc);
  assign thresh_ext  = CmpW'(cfg_i.long_press_threshold);
  assign idle_ext    = CmpW'(cfg_i.idle_timeout);
  assign sample      = (countdown_q == '0);

  always_comb begin
    pressed_d   = pressed_q;
    elapsed_d   = elapsed_q;
    countdown_d = countdown_q;
    res_o       = '0;
    res_valid_o = 1'b0;
    if (tick_i) begin
      elapsed_d = elapsed_inc;
      if (!sample) begin
        countdown_d = countdown_q - 1'b1;
      end else begin
        res_valid_o = 1'b1;
        // An interval of zero behaves as one: every tick is sampled.
        countdown_d = (cfg_i.sample_interval == '0) ? '0 : cfg_i.sample_interval - 1'b1;
        if (!pin_level_i) begin
          res_o.is_pressed = 1'b1;
          if (!pressed_q) begin
            res_o.press_event = 1'b1;
            pressed_d         = 1'b1;
            elapsed_d         = '0;
          end
        end else if (pressed_q) begin
          res_o.release_event = 1'b1;
          res_o.short_press   = (elapsed_ext < thresh_ext);
          res_o.long_press    = !(elapsed_ext < thresh_ext);
          pressed_d           = 1'b0;
          elapsed_d           = '0;
        end else begin
          res_o.idle_flag = (elapsed_ext > idle_ext);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q   <= 1'b0;
      elapsed_q   <= '0;
      countdown_q <= '0;
    end else begin
      pressed_q   <= pressed_d;
      elapsed_q   <= elapsed_d;
      countdown_q <= countdown_d;
    end
  end

endmodule

`default_nettype wire

>>> design/button_press_classifier_unit.sv
// Button press classifier: one millisecond tick per input request, and one
// result request for every sampled tick.
//
// Channels: the input carries pin_level_i (0 = pressed) under in_valid_i /
// in_stall_o. Results leave on out_valid_o / out_stall_i with is_pressed,
// press_event, release_event, short_press, long_press and idle_flag.
// Configuration writes use cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i: 0 idle timeout, 1 long press threshold, 2 sample interval;
// other indexes are dropped. Write only while the block is idle.
// Timing: an accepted tick lands in the input register; when it moves on,
// the classifier updates its state and, on a sampled tick, loads the result
// register, from which the result drives the outputs.
// One tick is taken every cycle while no result waits under out_stall_i.
// A sample happens on the first tick after reset and then once every
// sample_interval ticks; other ticks give no result.
// Reset: released state, elapsed timer and countdown at zero, registers at
// 3000 / 200 / 20, both pipeline registers empty.
// Stall: while a result waits under out_stall_i, a held tick stays in the
// input register and in_stall_o is raised; ticks giving no result still
// pass only when the result register can move.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_core.
`default_nettype none

module button_press_classifier_unit
  import bpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  pin_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       is_pressed_o,
  output logic                       press_event_o,
  output logic                       release_event_o,
  output logic                       short_press_o,
  output logic                       long_press_o,
  output logic                       idle_flag_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  result_t core_res;
  result_t res_q;
  logic    core_valid;
  logic    in_valid_q, in_valid_d;
  logic    pin_q;
  logic    out_valid_q, out_valid_d;
  logic    out_free, advance, in_accept;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held tick moves on only when the result register can take a result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  bpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (advance),
    .pin_level_i (pin_q),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = core_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pin_q <= pin_level_i;
    end
    if (out_free && core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_pressed_o    = res_q.is_pressed;
  assign press_event_o   = res_q.press_event;
  assign release_event_o = res_q.release_event;
  assign short_press_o   = res_q.short_press;
  assign long_press_o    = res_q.long_press;
  assign idle_flag_o     = res_q.idle_flag;

endmodule

`default_nettype wire
